// ----- src/tapid_pkg.sv -----
// ----------------------------------------------------------------------------
// tapid_pkg: shared types, constants and functions
// Widths, fixed-point constants, pulse-to-angle map and output saturation for
// the three-axis attitude PID controller.
// ----------------------------------------------------------------------------
package tapid_pkg;

   localparam int NUM_AXES = 3;
   localparam int AX_ROLL  = 0;
   localparam int AX_PITCH = 1;
   localparam int AX_YAW   = 2;

   // field widths
   localparam int PULSE_W = 12;
   localparam int ANGLE_W = 15;
   localparam int DRIVE_W = 16;
   localparam int GAIN_W  = 16;
   localparam int CSR_W   = 3 * GAIN_W;
   localparam int CSR_IDX_W = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ROLL_GAINS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PITCH_GAINS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_YAW_GAINS   = 2'd2;

   // fixed point
   localparam int OUTPUT_LIMIT    = 400;
   localparam int ANGLE_FRAC_BITS = 6;
   localparam int GAIN_FRAC_BITS  = 8;
   localparam int LIMIT           = OUTPUT_LIMIT * (1 << ANGLE_FRAC_BITS);

   // pulse map: deg = trunc((pulse - 1000) * 3 / 50) - 30
   localparam int PULSE_ZERO  = 1000;
   localparam int DEG_OFFSET  = 30;
   localparam int MAP_SHIFT   = 20;
   localparam int MAP_RECIP   = 20972;         // ceil(2^20 / 50)
   localparam int MAG3_W      = PULSE_W + 2;
   localparam int MAP_PROD_W  = MAG3_W + 15;
   localparam int DEG_W       = 9;

   // error path
   localparam int DELTA_W = ANGLE_W + 1;
   localparam int ERR_W   = 22;
   localparam int DIFF_W  = ERR_W + 1;
   localparam int INTEG_W = 16;

   // products and sums
   localparam int PROD_W    = GAIN_W + 1 + ERR_W;
   localparam int DPROD_W   = GAIN_W + 1 + DIFF_W;
   localparam int PD_SUM_W  = DPROD_W + 1;
   localparam int PD_W      = PD_SUM_W - GAIN_FRAC_BITS;
   localparam int SAT_W     = PD_SUM_W;

   typedef logic signed [ERR_W-1:0]   err_type;
   typedef logic signed [PD_W-1:0]    pd_type;
   typedef logic signed [INTEG_W-1:0] integ_type;

   typedef struct packed {
      logic load_err;
      logic load_prod;
      logic load_out;
   } lane_ctl_type;

   function automatic logic signed [DEG_W-1:0] map_deg(input logic [PULSE_W-1:0] pulse);
      logic signed [PULSE_W:0]   delta_us;
      logic [PULSE_W-1:0]        mag;
      logic [MAG3_W-1:0]         scaled;
      logic [MAP_PROD_W-1:0]     prod;
      logic [DEG_W-2:0]          quo;
      logic signed [DEG_W-1:0]   sq;
      delta_us = $signed({1'b0, pulse}) - $signed((PULSE_W+1)'(PULSE_ZERO));
      mag      = delta_us[PULSE_W] ? PULSE_W'(-delta_us) : delta_us[PULSE_W-1:0];
      scaled   = {2'b00, mag} + {1'b0, mag, 1'b0};
      prod     = MAP_PROD_W'(scaled) * MAP_PROD_W'(MAP_RECIP);
      quo      = prod[MAP_SHIFT +: DEG_W-1];
      // truncate toward zero: divide the magnitude, then restore the sign
      sq       = delta_us[PULSE_W] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
      return sq - $signed(DEG_W'(DEG_OFFSET));
   endfunction

   function automatic logic signed [INTEG_W-1:0] saturate(input logic signed [SAT_W-1:0] v);
      logic signed [SAT_W-1:0] lim;
      lim = SAT_W'(LIMIT);
      if (v > lim) begin
         return INTEG_W'(LIMIT);
      end else if (v < -lim) begin
         return INTEG_W'(-LIMIT);
      end
      return INTEG_W'(v);
   endfunction

endpackage

// ----- src/tapid_channels.sv -----
// ----------------------------------------------------------------------------
// tapid channels: request and response interfaces
// Valid/ready channels carrying stick pulses with measured attitude in, and
// the three axis drives out.
// ----------------------------------------------------------------------------
interface tapid_req_if;
   logic                                       valid;
   logic                                       ready;
   logic [tapid_pkg::PULSE_W-1:0]              roll_pulse;
   logic [tapid_pkg::PULSE_W-1:0]              pitch_pulse;
   logic [tapid_pkg::PULSE_W-1:0]              yaw_pulse;
   logic signed [tapid_pkg::ANGLE_W-1:0]       roll_angle;
   logic signed [tapid_pkg::ANGLE_W-1:0]       pitch_angle;
   logic signed [tapid_pkg::ANGLE_W-1:0]       yaw_angle;

   modport source (output valid, roll_pulse, pitch_pulse, yaw_pulse,
                   roll_angle, pitch_angle, yaw_angle, input ready);
   modport sink   (input valid, roll_pulse, pitch_pulse, yaw_pulse,
                   roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

interface tapid_rsp_if;
   logic                                       valid;
   logic                                       ready;
   logic signed [tapid_pkg::DRIVE_W-1:0]       roll_drive;
   logic signed [tapid_pkg::DRIVE_W-1:0]       pitch_drive;
   logic signed [tapid_pkg::DRIVE_W-1:0]       yaw_drive;

   modport source (output valid, roll_drive, pitch_drive, yaw_drive, input ready);
   modport sink   (input valid, roll_drive, pitch_drive, yaw_drive, output ready);
endinterface

// ----- src/tapid_front.sv -----
// ----------------------------------------------------------------------------
// tapid_front: stick mapping and error formation
// Maps the three pulses to degrees in three lanes, registers them with the
// measured angles, and forms the per-axis error from the registered values.
// ----------------------------------------------------------------------------
module tapid_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  load,
   input  logic [tapid_pkg::PULSE_W-1:0]         roll_pulse,
   input  logic [tapid_pkg::PULSE_W-1:0]         pitch_pulse,
   input  logic [tapid_pkg::PULSE_W-1:0]         yaw_pulse,
   input  logic signed [tapid_pkg::ANGLE_W-1:0]  roll_angle,
   input  logic signed [tapid_pkg::ANGLE_W-1:0]  pitch_angle,
   input  logic signed [tapid_pkg::ANGLE_W-1:0]  yaw_angle,
   output tapid_pkg::err_type                    err [tapid_pkg::NUM_AXES]
);

   logic [tapid_pkg::PULSE_W-1:0]          pulse [tapid_pkg::NUM_AXES];
   logic signed [tapid_pkg::DEG_W-1:0]     deg_in [tapid_pkg::NUM_AXES];
   logic signed [tapid_pkg::DEG_W-1:0]     deg_ff [tapid_pkg::NUM_AXES];
   logic signed [tapid_pkg::ANGLE_W-1:0]   roll_angle_ff;
   logic signed [tapid_pkg::ANGLE_W-1:0]   pitch_angle_ff;
   logic signed [tapid_pkg::DELTA_W-1:0]   yaw_delta_in;
   logic signed [tapid_pkg::DELTA_W-1:0]   yaw_delta_ff;
   logic signed [tapid_pkg::ANGLE_W-1:0]   last_yaw_in;
   logic signed [tapid_pkg::ANGLE_W-1:0]   last_yaw_ff;
   tapid_pkg::err_type                     yaw_d;
   tapid_pkg::err_type                     yaw_rate;
   tapid_pkg::err_type                     yaw_stick;

   assign pulse[tapid_pkg::AX_ROLL]  = roll_pulse;
   assign pulse[tapid_pkg::AX_PITCH] = pitch_pulse;
   assign pulse[tapid_pkg::AX_YAW]   = yaw_pulse;

   always_comb begin
      for (int i = 0; i < tapid_pkg::NUM_AXES; i++) begin
         deg_in[i] = tapid_pkg::map_deg(pulse[i]);
      end
      yaw_delta_in = tapid_pkg::DELTA_W'(last_yaw_ff) - tapid_pkg::DELTA_W'(yaw_angle);
      last_yaw_in  = load ? yaw_angle : last_yaw_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_yaw_ff <= '0;
      end else begin
         last_yaw_ff <= last_yaw_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         deg_ff         <= deg_in;
         roll_angle_ff  <= roll_angle;
         pitch_angle_ff <= pitch_angle;
         yaw_delta_ff   <= yaw_delta_in;
      end
   end

   // yaw: stick angle is negated; a neutral stick selects 50x the heading change
   always_comb begin
      yaw_d     = tapid_pkg::ERR_W'(yaw_delta_ff);
      yaw_rate  = (yaw_d <<< 5) + (yaw_d <<< 4) + (yaw_d <<< 1);
      yaw_stick = tapid_pkg::ERR_W'(deg_ff[tapid_pkg::AX_YAW]) <<< tapid_pkg::ANGLE_FRAC_BITS;
      err[tapid_pkg::AX_ROLL] = tapid_pkg::ERR_W'(roll_angle_ff)
         - (tapid_pkg::ERR_W'(deg_ff[tapid_pkg::AX_ROLL]) <<< tapid_pkg::ANGLE_FRAC_BITS);
      err[tapid_pkg::AX_PITCH] = tapid_pkg::ERR_W'(pitch_angle_ff)
         - (tapid_pkg::ERR_W'(deg_ff[tapid_pkg::AX_PITCH]) <<< tapid_pkg::ANGLE_FRAC_BITS);
      if (deg_ff[tapid_pkg::AX_YAW] == '0) begin
         err[tapid_pkg::AX_YAW] = yaw_rate;
      end else begin
         err[tapid_pkg::AX_YAW] = -yaw_stick;
      end
   end

endmodule

// ----- src/tapid_axis.sv -----
// ----------------------------------------------------------------------------
// tapid_axis: one PID lane
// Registers the error and its change, forms the three gain products, then
// advances the clamped integrator and the combined P plus D term.
// ----------------------------------------------------------------------------
module tapid_axis (
   input  logic                            clock,
   input  logic                            reset,
   input  tapid_pkg::lane_ctl_type         ctl,
   input  logic [tapid_pkg::CSR_W-1:0]     gains,
   input  tapid_pkg::err_type              err,
   output tapid_pkg::pd_type               pd,
   output tapid_pkg::integ_type            integ
);

   logic [tapid_pkg::GAIN_W-1:0]            kp;
   logic [tapid_pkg::GAIN_W-1:0]            ki;
   logic [tapid_pkg::GAIN_W-1:0]            kd;
   tapid_pkg::err_type                      err_ff;
   tapid_pkg::err_type                      last_err_in;
   tapid_pkg::err_type                      last_err_ff;
   logic signed [tapid_pkg::DIFF_W-1:0]     diff_in;
   logic signed [tapid_pkg::DIFF_W-1:0]     diff_ff;
   logic signed [tapid_pkg::PROD_W-1:0]     kpe_in;
   logic signed [tapid_pkg::PROD_W-1:0]     kpe_ff;
   logic signed [tapid_pkg::PROD_W-1:0]     kie_in;
   logic signed [tapid_pkg::PROD_W-1:0]     kie_ff;
   logic signed [tapid_pkg::DPROD_W-1:0]    kdd_in;
   logic signed [tapid_pkg::DPROD_W-1:0]    kdd_ff;
   logic signed [tapid_pkg::PD_SUM_W-1:0]   pd_sum;
   tapid_pkg::pd_type                       pd_in;
   tapid_pkg::pd_type                       pd_ff;
   tapid_pkg::integ_type                    integ_in;
   tapid_pkg::integ_type                    integ_ff;

   assign kp = gains[0 +: tapid_pkg::GAIN_W];
   assign ki = gains[tapid_pkg::GAIN_W +: tapid_pkg::GAIN_W];
   assign kd = gains[2*tapid_pkg::GAIN_W +: tapid_pkg::GAIN_W];

   always_comb begin
      diff_in     = tapid_pkg::DIFF_W'(err) - tapid_pkg::DIFF_W'(last_err_ff);
      last_err_in = ctl.load_err ? err : last_err_ff;
      kpe_in = tapid_pkg::PROD_W'($signed({1'b0, kp})) * tapid_pkg::PROD_W'(err_ff);
      kie_in = tapid_pkg::PROD_W'($signed({1'b0, ki})) * tapid_pkg::PROD_W'(err_ff);
      kdd_in = tapid_pkg::DPROD_W'($signed({1'b0, kd})) * tapid_pkg::DPROD_W'(diff_ff);
      // floor division by the gain scale is an arithmetic shift of the exact value
      integ_in = tapid_pkg::saturate(tapid_pkg::SAT_W'(integ_ff)
                    + tapid_pkg::SAT_W'(kie_ff >>> tapid_pkg::GAIN_FRAC_BITS));
      pd_sum   = tapid_pkg::PD_SUM_W'(kpe_ff) + tapid_pkg::PD_SUM_W'(kdd_ff);
      pd_in    = tapid_pkg::PD_W'(pd_sum >>> tapid_pkg::GAIN_FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_err_ff <= '0;
         integ_ff    <= '0;
      end else begin
         last_err_ff <= last_err_in;
         if (ctl.load_out) begin
            integ_ff <= integ_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_err) begin
         err_ff  <= err;
         diff_ff <= diff_in;
      end
      if (ctl.load_prod) begin
         kpe_ff <= kpe_in;
         kie_ff <= kie_in;
         kdd_ff <= kdd_in;
      end
      if (ctl.load_out) begin
         pd_ff <= pd_in;
      end
   end

   // integrator holds the value of the word last loaded into the last stage
   assign pd    = pd_ff;
   assign integ = integ_ff;

   a_integ_range: assert property (@(posedge clock) disable iff (reset)
      (integ_ff <= tapid_pkg::INTEG_W'(tapid_pkg::LIMIT))
      && (integ_ff >= tapid_pkg::INTEG_W'(-tapid_pkg::LIMIT)))
      else $error("integrator outside limit");

   a_hist_hold: assert property (@(posedge clock) disable iff (reset)
      !ctl.load_err |=> $stable(last_err_ff))
      else $error("error history changed without a word");

   a_integ_hold: assert property (@(posedge clock) disable iff (reset)
      !ctl.load_out |=> $stable(integ_ff))
      else $error("integrator changed without a word");

endmodule

// ----- src/three_axis_attitude_pid.sv -----
// ----------------------------------------------------------------------------
// three_axis_attitude_pid: three-axis attitude PID with integrator clamp
// Stick pulses and measured attitude in, saturated roll/pitch/yaw drives out;
// three PID lanes run side by side and merge into one output register.
//
//   channel  | direction | handshake       | payload
//   req_ch   | in        | valid / ready   | 3 pulses (12b), 3 angles (15b signed)
//   rsp_ch   | out       | valid / ready   | 3 drives (16b signed)
//   csr_*    | in        | csr_wr_en       | csr_index (2b), csr_wdata (48b)
//
// One word per cycle sustained while rsp_ch is not stalled; each accepted word
// passes the map, error, gain-product, integrator/PD and merge/saturate registers.
// The integrator and error-history registers in each lane close the loop.
// Synchronous reset clears gains, integrators, error history and last yaw.
// A stalled response backs up the stages; req_ch.ready drops only when every
// stage holds a word.
// ----------------------------------------------------------------------------
module three_axis_attitude_pid (
   input  logic                                 clock,
   input  logic                                 reset,
   tapid_req_if.sink                            req_ch,
   tapid_rsp_if.source                          rsp_ch,
   input  logic                                 csr_wr_en,
   input  logic [tapid_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tapid_pkg::CSR_W-1:0]          csr_wdata
);

   logic [tapid_pkg::CSR_W-1:0]            gain_ff [tapid_pkg::NUM_AXES];
   tapid_pkg::err_type                     err [tapid_pkg::NUM_AXES];
   tapid_pkg::pd_type                      pd [tapid_pkg::NUM_AXES];
   tapid_pkg::integ_type                   integ [tapid_pkg::NUM_AXES];
   logic signed [tapid_pkg::DRIVE_W-1:0]   drive_in [tapid_pkg::NUM_AXES];
   logic signed [tapid_pkg::DRIVE_W-1:0]   drive_ff [tapid_pkg::NUM_AXES];
   tapid_pkg::lane_ctl_type                ctl;

   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, rsp_vld_ff;
   logic s1_vld_in, s2_vld_in, s3_vld_in, s4_vld_in, rsp_vld_in;
   logic go1, go2, go3, go4, go5;
   logic free1, free2, free3, free4;

   // ready ripples back from the output; a stage loads when the next one frees
   always_comb begin
      go5   = s4_vld_ff && (!rsp_vld_ff || rsp_ch.ready);
      free4 = !s4_vld_ff || go5;
      go4   = s3_vld_ff && free4;
      free3 = !s3_vld_ff || go4;
      go3   = s2_vld_ff && free3;
      free2 = !s2_vld_ff || go3;
      go2   = s1_vld_ff && free2;
      free1 = !s1_vld_ff || go2;
      go1   = req_ch.valid && free1;

      s1_vld_in  = go1 || (s1_vld_ff && !go2);
      s2_vld_in  = go2 || (s2_vld_ff && !go3);
      s3_vld_in  = go3 || (s3_vld_ff && !go4);
      s4_vld_in  = go4 || (s4_vld_ff && !go5);
      rsp_vld_in = go5 || (rsp_vld_ff && !rsp_ch.ready);

      ctl.load_err  = go2;
      ctl.load_prod = go3;
      ctl.load_out  = go4;
   end

   assign req_ch.ready = free1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         s2_vld_ff  <= s2_vld_in;
         s3_vld_ff  <= s3_vld_in;
         s4_vld_ff  <= s4_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // gain registers; an unused index drops the write
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tapid_pkg::NUM_AXES; i++) begin
            gain_ff[i] <= '0;
         end
      end else if (csr_wr_en) begin
         case (csr_index)
            tapid_pkg::REG_ROLL_GAINS:  gain_ff[tapid_pkg::AX_ROLL]  <= csr_wdata;
            tapid_pkg::REG_PITCH_GAINS: gain_ff[tapid_pkg::AX_PITCH] <= csr_wdata;
            tapid_pkg::REG_YAW_GAINS:   gain_ff[tapid_pkg::AX_YAW]   <= csr_wdata;
            default: ;
         endcase
      end
   end

   tapid_front u_front (
      .clock       (clock),
      .reset       (reset),
      .load        (go1),
      .roll_pulse  (req_ch.roll_pulse),
      .pitch_pulse (req_ch.pitch_pulse),
      .yaw_pulse   (req_ch.yaw_pulse),
      .roll_angle  (req_ch.roll_angle),
      .pitch_angle (req_ch.pitch_angle),
      .yaw_angle   (req_ch.yaw_angle),
      .err         (err)
   );

   for (genvar g = 0; g < tapid_pkg::NUM_AXES; g++) begin : g_lane
      tapid_axis u_axis (
         .clock (clock),
         .reset (reset),
         .ctl   (ctl),
         .gains (gain_ff[g]),
         .err   (err[g]),
         .pd    (pd[g]),
         .integ (integ[g])
      );
   end

   // merge: drive = sat(pd + integrator) per lane
   always_comb begin
      for (int i = 0; i < tapid_pkg::NUM_AXES; i++) begin
         drive_in[i] = tapid_pkg::saturate(tapid_pkg::SAT_W'(pd[i])
                          + tapid_pkg::SAT_W'(integ[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (go5) begin
         drive_ff <= drive_in;
      end
   end

   assign rsp_ch.valid       = rsp_vld_ff;
   assign rsp_ch.roll_drive  = drive_ff[tapid_pkg::AX_ROLL];
   assign rsp_ch.pitch_drive = drive_ff[tapid_pkg::AX_PITCH];
   assign rsp_ch.yaw_drive   = drive_ff[tapid_pkg::AX_YAW];

   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (drive_ff[tapid_pkg::AX_YAW] <= tapid_pkg::DRIVE_W'(tapid_pkg::LIMIT))
                  && (drive_ff[tapid_pkg::AX_YAW] >= tapid_pkg::DRIVE_W'(-tapid_pkg::LIMIT)))
      else $error("yaw drive outside limit");

   a_stall_holds_s4: assert property (@(posedge clock) disable iff (reset)
      (s4_vld_ff && rsp_vld_ff && !rsp_ch.ready) |=> s4_vld_ff)
      else $error("last stage lost a word under stall");

   a_full_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && s2_vld_ff && s3_vld_ff && s4_vld_ff && rsp_vld_ff && !rsp_ch.ready)
      |-> !req_ch.ready)
      else $error("word accepted into a full pipeline");

endmodule
